FILE: rtl/line_segment_triangle_test_assert.svh
// Assertion macros used by the checker of line_segment_triangle_test.
// Uses the clk and rst names of the module that expands them.
`ifndef LINE_SEGMENT_TRIANGLE_TEST_ASSERT_SVH
`define LINE_SEGMENT_TRIANGLE_TEST_ASSERT_SVH

// Same-cycle implication.
`define LST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lst_pkg.sv
// Shared widths, codes and controller/datapath command types for the
// segment/triangle test. No dependencies.
`timescale 1ns / 1ps

package lst_pkg;

  localparam int CW  = 16;               // coordinate width
  localparam int SW  = CW + 1;           // point difference width
  localparam int NW  = 2 * SW + 1;       // normal component width
  localparam int DW  = NW + SW + 2;      // distance / edge vector width
  localparam int HW  = (DW + 1) / 2;     // half of a wide operand
  localparam int WW  = 2 * HW;           // wide operand register width
  localparam int AW  = WW + SW + 2;      // accumulator width
  localparam int QW  = CW + 1;           // quotient magnitude width
  localparam int DCW = $clog2(QW + 1);   // divider step counter width
  localparam int TDW = ((3 * CW + 7) / 8) * 8;

  localparam logic [2:0] KIND_V0 = 3'd0;
  localparam logic [2:0] KIND_V1 = 3'd1;
  localparam logic [2:0] KIND_V2 = 3'd2;
  localparam logic [2:0] KIND_S  = 3'd3;
  localparam logic [2:0] KIND_E  = 3'd4;

  // Difference vectors of stored points
  typedef enum logic [3:0] {
    SV_E1, SV_E2, SV_L1, SV_L2, SV_DF, SV_E3, SV_E4, SV_W0, SV_W1
  } svec_t;

  // Wide multiplier operand
  typedef enum logic [1:0] {WS_E1, WS_N, WS_T, WS_D1} wsrc_t;

  // Accumulator write target
  typedef enum logic [2:0] {WD_NONE, WD_N, WD_T, WD_D1, WD_D2} wdst_t;

  typedef struct packed {
    logic       load;
    svec_t      sa_vec;
    logic [1:0] sa_comp;
    wsrc_t      sb_src;
    logic [1:0] sb_comp;
    logic       half;
    logic       neg;
    logic       clr;
    logic       mac;
    wdst_t      wr_dst;
    logic [1:0] wr_comp;
    logic       den_ld;
    logic       div_ld;
    logic       div_step;
    logic       p_wr;
    logic       out_wr;
    logic       out_hit;
  } cmd_t;

  typedef struct packed {
    logic d_fail;
    logic acc_neg;
  } stat_t;

endpackage

FILE: rtl/line_segment_triangle_test.sv
// Load beats (kinds 0-3, 5-7) are taken while idle; a segment-end beat starts
// a test whose result comes after the distance check when an end sits on the plane or
// both ends on one side of it, and later, at most at the end of the full test, otherwise (plus any output stall).
// Throughput: one test at a time, set by the shared 17x28 multiplier (42
// products) and the 17-step restoring divider.
// Reset (rst, synchronous) clears the stored points V0, V1, V2 and S to zero and idles.
`timescale 1ns / 1ps

module line_segment_triangle_test (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [lst_pkg::TDW-1:0] s_tdata,  // x, y, z (low to high)
  input  logic [2:0]              s_tuser,  // kind
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [lst_pkg::TDW-1:0] m_tdata,  // hit_x, hit_y, hit_z (low to high)
  output logic                    m_tuser   // hit
);
  import lst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller walks a fixed program: N = (V1-V0) x (V2-V0), the two
  // signed distances and their check, the per-axis hit point (product then
  // divide) and a side test per edge. The product steps drive the shared MAC.
  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the points and the result register; a finished result
  // waits there while the next points are loaded.
  lst_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

FILE: rtl/lst_datapath.sv
// Datapath: point store, shared split multiply-accumulate, restoring divider
// and result register. Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [lst_pkg::TDW-1:0] s_tdata,
  input  logic [2:0]              s_tuser,
  input  lst_pkg::cmd_t           cmd,
  output lst_pkg::stat_t          stat,
  output logic [lst_pkg::TDW-1:0] m_tdata,
  output logic                    m_tuser
);
  import lst_pkg::*;

  logic [3*CW-1:0] v0, v1, v2, sp, ep, pp;
  logic [3*WW-1:0] nv, tv;
  logic signed [WW-1:0] d1, d2;
  logic signed [AW-1:0] acc, acc_next, acc_base, pext, psh;
  logic [WW:0] dmag;
  logic signed [WW:0] dd;
  logic [AW-1:0] rem, dsh;
  logic [QW-1:0] q;
  logic [3*CW-1:0] mina, suba;
  logic signed [SW-1:0] sa, e1c;
  logic signed [WW-1:0] sb;
  logic signed [HW:0] part;
  logic signed [SW+HW:0] prod;
  logic signed [QW:0] qs, pval;
  logic [WW-1:0] wval;
  logic ge;

  function automatic logic signed [CW-1:0] crd(input logic [3*CW-1:0] v,
                                               input logic [1:0] c);
    case (c)
      2'd0:    return v[CW-1:0];
      2'd1:    return v[2*CW-1:CW];
      default: return v[3*CW-1:2*CW];
    endcase
  endfunction

  function automatic logic signed [WW-1:0] wpick(input logic [3*WW-1:0] v,
                                                 input logic [1:0] c);
    case (c)
      2'd0:    return v[WW-1:0];
      2'd1:    return v[2*WW-1:WW];
      default: return v[3*WW-1:2*WW];
    endcase
  endfunction

  // Short operand: one component of a point difference
  always_comb begin
    unique case (cmd.sa_vec)
      SV_E1:   begin mina = v1; suba = v0; end
      SV_E2:   begin mina = v2; suba = v0; end
      SV_L1:   begin mina = sp; suba = v0; end
      SV_L2:   begin mina = ep; suba = v0; end
      SV_DF:   begin mina = ep; suba = sp; end
      SV_E3:   begin mina = v2; suba = v1; end
      SV_E4:   begin mina = v0; suba = v2; end
      SV_W0:   begin mina = pp; suba = v0; end
      SV_W1:   begin mina = pp; suba = v1; end
      default: begin mina = v1; suba = v0; end
    endcase
    sa = SW'(crd(mina, cmd.sa_comp)) - SW'(crd(suba, cmd.sa_comp));
  end

  // Wide operand, fed to the multiplier one half at a time
  always_comb begin
    e1c = SW'(crd(v1, cmd.sb_comp)) - SW'(crd(v0, cmd.sb_comp));
    unique case (cmd.sb_src)
      WS_E1:   sb = WW'(e1c);
      WS_N:    sb = wpick(nv, cmd.sb_comp);
      WS_T:    sb = wpick(tv, cmd.sb_comp);
      default: sb = d1;
    endcase
    part = cmd.half ? {sb[WW-1], sb[WW-1:HW]} : {1'b0, sb[HW-1:0]};
  end

  assign prod     = sa * part;
  assign pext     = AW'(prod);
  assign psh      = cmd.half ? {pext[AW-HW-1:0], {HW{1'b0}}} : pext;
  assign acc_base = cmd.clr ? '0 : acc;
  assign acc_next = cmd.neg ? acc_base - psh : acc_base + psh;
  assign wval     = acc_next[WW-1:0];

  assign dd = (WW+1)'(d2) - (WW+1)'(d1);
  assign ge = rem >= dsh;
  assign qs = sa[SW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign pval = (QW+1)'(crd(sp, cmd.sa_comp)) + qs;

  assign stat.d_fail  = (d1 == '0) || (d2 == '0) || (d1[WW-1] == d2[WW-1]);
  assign stat.acc_neg = acc[AW-1];

  // Point store for V0, V1, V2 and S, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '0;
      v1 <= '0;
      v2 <= '0;
      sp <= '0;
    end else if (cmd.load) begin
      unique case (s_tuser)
        KIND_V0: v0 <= s_tdata[3*CW-1:0];
        KIND_V1: v1 <= s_tdata[3*CW-1:0];
        KIND_V2: v2 <= s_tdata[3*CW-1:0];
        KIND_S:  sp <= s_tdata[3*CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && s_tuser == KIND_E) ep <= s_tdata[3*CW-1:0];
    if (cmd.mac) acc <= acc_next;
    case (cmd.wr_dst)
      WD_N: begin
        case (cmd.wr_comp)
          2'd0:    nv[WW-1:0]      <= wval;
          2'd1:    nv[2*WW-1:WW]   <= wval;
          default: nv[3*WW-1:2*WW] <= wval;
        endcase
      end
      WD_T: begin
        case (cmd.wr_comp)
          2'd0:    tv[WW-1:0]      <= wval;
          2'd1:    tv[2*WW-1:WW]   <= wval;
          default: tv[3*WW-1:2*WW] <= wval;
        endcase
      end
      WD_D1:   d1 <= wval;
      WD_D2:   d2 <= wval;
      default: ;
    endcase
    if (cmd.den_ld) dmag <= dd[WW] ? -dd : dd;
    if (cmd.div_ld) begin
      rem <= acc[AW-1] ? -acc : acc;
      dsh <= AW'({dmag, {CW{1'b0}}});
      q   <= '0;
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dsh;
      q   <= {q[QW-2:0], ge};
      dsh <= dsh >> 1;
    end
    if (cmd.p_wr) begin
      case (cmd.sa_comp)
        2'd0:    pp[CW-1:0]      <= pval[CW-1:0];
        2'd1:    pp[2*CW-1:CW]   <= pval[CW-1:0];
        default: pp[3*CW-1:2*CW] <= pval[CW-1:0];
      endcase
    end
    if (cmd.out_wr) begin
      m_tuser <= cmd.out_hit;
      m_tdata <= TDW'(cmd.out_hit ? pp : '0);
    end
  end

endmodule

FILE: rtl/lst_ctrl.sv
// Sequencer for the segment/triangle test: steps the shared multiply-
// accumulate, divider and checks. Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic [2:0]     s_tuser,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  lst_pkg::stat_t stat,
  output lst_pkg::cmd_t  cmd
);
  import lst_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_PWR, ST_DONE} state_t;
  typedef enum logic [2:0] {OP_CROSS, OP_DOT, OP_MUL, OP_CHKD, OP_CHKE, OP_HIT} op_t;

  state_t state;
  logic [4:0] pc;
  logic [1:0] k, mcomp;
  logic term, half, hit, fin;
  logic [DCW-1:0] dcnt;
  op_t op;
  svec_t op_sa;
  wsrc_t op_sb;
  wdst_t op_dst;

  function automatic logic [1:0] inc3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  // Program: normal, distances, distance check, hit point, then an edge-side test per edge
  always_comb begin
    op = OP_HIT; op_sa = SV_E1; op_sb = WS_N; op_dst = WD_NONE;
    unique case (pc)
      5'd0:  begin op = OP_CROSS; op_sa = SV_E2; op_sb = WS_E1; op_dst = WD_N; end
      5'd1:  begin op = OP_DOT;   op_sa = SV_L1; op_dst = WD_D1; end
      5'd2:  begin op = OP_DOT;   op_sa = SV_L2; op_dst = WD_D2; end
      5'd3:  op = OP_CHKD;
      5'd4, 5'd5, 5'd6: begin op = OP_MUL; op_sa = SV_DF; op_sb = WS_D1; end
      5'd7:  begin op = OP_CROSS; op_sa = SV_E1; op_dst = WD_T; end
      5'd8:  begin op = OP_DOT;   op_sa = SV_W0; op_sb = WS_T; end
      5'd9:  op = OP_CHKE;
      5'd10: begin op = OP_CROSS; op_sa = SV_E3; op_dst = WD_T; end
      5'd11: begin op = OP_DOT;   op_sa = SV_W1; op_sb = WS_T; end
      5'd12: op = OP_CHKE;
      5'd13: begin op = OP_CROSS; op_sa = SV_E4; op_dst = WD_T; end
      5'd14: begin op = OP_DOT;   op_sa = SV_W0; op_sb = WS_T; end
      5'd15: op = OP_CHKE;
      default: op = OP_HIT;
    endcase
  end

  assign mcomp    = 2'(pc - 5'd4);
  assign s_tready = (state == ST_IDLE);
  assign fin = half && ((op == OP_CROSS) ? (term && k == 2'd2) :
                        (op == OP_DOT)   ? (k == 2'd2) : 1'b1);

  always_comb begin
    cmd         = '0;
    cmd.load    = s_tvalid && s_tready;
    cmd.sa_vec  = op_sa;
    cmd.sb_src  = op_sb;
    cmd.half    = half;
    cmd.wr_comp = k;
    cmd.out_hit = hit;
    unique case (state)
      ST_EXEC: begin
        unique case (op) inside
          OP_CROSS: begin
            cmd.mac     = 1'b1;
            cmd.sa_comp = term ? inc3(k) : inc3(inc3(k));
            cmd.sb_comp = term ? inc3(inc3(k)) : inc3(k);
            cmd.neg     = term;
            cmd.clr     = !term && !half;
            if (term && half) cmd.wr_dst = op_dst;
          end
          OP_DOT: begin
            cmd.mac     = 1'b1;
            cmd.sa_comp = k;
            cmd.sb_comp = k;
            cmd.clr     = (k == 2'd0) && !half;
            if (k == 2'd2 && half) cmd.wr_dst = op_dst;
          end
          OP_MUL: begin
            cmd.mac     = 1'b1;
            cmd.sa_comp = mcomp;
            cmd.clr     = !half;
          end
          OP_CHKD: cmd.den_ld = !stat.d_fail;
          default: ;
        endcase
      end
      ST_DIV: begin
        cmd.div_ld   = (dcnt == '0);
        cmd.div_step = (dcnt != '0);
      end
      ST_PWR: begin
        cmd.sa_vec  = SV_DF;
        cmd.sa_comp = mcomp;
        cmd.p_wr    = 1'b1;
      end
      ST_DONE: cmd.out_wr = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      k        <= '0;
      term     <= 1'b0;
      half     <= 1'b0;
      dcnt     <= '0;
      hit      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser == KIND_E) begin
            state <= ST_EXEC;
            pc    <= '0;
            k     <= '0;
            term  <= 1'b0;
            half  <= 1'b0;
          end
        end
        ST_EXEC: begin
          unique case (op) inside
            OP_CROSS, OP_DOT, OP_MUL: begin
              if (fin) begin
                k    <= '0;
                term <= 1'b0;
                half <= 1'b0;
                if (op == OP_MUL) begin
                  state <= ST_DIV;
                  dcnt  <= '0;
                end else begin
                  pc <= pc + 5'd1;
                end
              end else begin
                half <= !half;
                if (half) begin
                  if (op == OP_CROSS && !term) begin
                    term <= 1'b1;
                  end else begin
                    term <= 1'b0;
                    k    <= inc3(k);
                  end
                end
              end
            end
            OP_CHKD: begin
              if (stat.d_fail) begin
                hit   <= 1'b0;
                state <= ST_DONE;
              end else begin
                pc <= pc + 5'd1;
              end
            end
            OP_CHKE: begin
              if (stat.acc_neg) begin
                hit   <= 1'b0;
                state <= ST_DONE;
              end else begin
                pc <= pc + 5'd1;
              end
            end
            OP_HIT: begin
              hit   <= 1'b1;
              state <= ST_DONE;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(QW)) state <= ST_PWR;
        end
        ST_PWR: begin
          pc    <= pc + 5'd1;
          state <= ST_EXEC;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lst_checker.sv
// Port-level checks for line_segment_triangle_test, bound to the top level.
// Depends on lst_pkg and line_segment_triangle_test_assert.svh.
`timescale 1ns / 1ps
`include "line_segment_triangle_test_assert.svh"

module lst_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic [lst_pkg::TDW-1:0] s_tdata,
  input logic [2:0]              s_tuser,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [lst_pkg::TDW-1:0] m_tdata,
  input logic                    m_tuser
);
  import lst_pkg::*;

  `LST_ASSERT_NXT(a_end_busy, s_tvalid && s_tready && s_tuser == KIND_E, !s_tready, "test beat did not stall input")
  `LST_ASSERT_NXT(a_load_quiet, s_tvalid && s_tready && s_tuser != KIND_E, s_tready && !$rose(m_tvalid), "load beat made a result")
  `LST_ASSERT_IMP(a_rise_busy, $rose(m_tvalid), !$past(s_tready), "result without a test")
  `LST_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss beat carries a point")

endmodule

bind line_segment_triangle_test lst_checker u_lst_checker (.*);
